>>> hw/rtl/mwpssd_pkg.sv
// ----------------------------------------------------------------------------
// mwpssd_pkg
// Types and constants shared by the masked weighted patch cost block.
// ----------------------------------------------------------------------------
package mwpssd_pkg;

   localparam int PIXEL_W    = 8;
   localparam int WEIGHT_W   = 16;
   localparam int SQ_W       = 2 * PIXEL_W;
   localparam int TERM_W     = SQ_W + WEIGHT_W;
   localparam int DIST_W     = 42;
   localparam int WSUM_W     = 26;
   localparam int COST_W     = 24;
   localparam int FRAC_SHIFT = 8;
   localparam int QUOT_W     = DIST_W + FRAC_SHIFT;
   localparam int STEP_W     = $clog2(QUOT_W);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [WEIGHT_W-1:0] ONE_Q12  = 16'd4096;
   localparam logic [COST_W-1:0]   COST_MAX = 24'd16646400;

   typedef struct packed {
      logic [DIST_W-1:0] dist_sum;
      logic [WSUM_W-1:0] wsum;
   } sums_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_HOLD
   } back_state_type;

endpackage

>>> hw/rtl/mwpssd_ifs.sv
// ----------------------------------------------------------------------------
// mwpssd channel interfaces
// Pixel request channel and cost response channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mwpssd_req_if;
   import mwpssd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [PIXEL_W-1:0]   source_pixel;
   logic [PIXEL_W-1:0]   known_pixel;
   logic [PIXEL_W-1:0]   dense_pixel;
   logic                 is_hole;
   logic                 last_pixel;

   modport source (
      output valid, source_pixel, known_pixel, dense_pixel, is_hole, last_pixel,
      input  ready
   );
   modport sink (
      input  valid, source_pixel, known_pixel, dense_pixel, is_hole, last_pixel,
      output ready
   );
endinterface

interface mwpssd_rsp_if;
   import mwpssd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [COST_W-1:0]    cost;
   logic                 zero_weight;

   modport source (
      output valid, cost, zero_weight,
      input  ready
   );
   modport sink (
      input  valid, cost, zero_weight,
      output ready
   );
endinterface

>>> hw/rtl/masked_weighted_patch_ssd.sv
// ----------------------------------------------------------------------------
// masked_weighted_patch_ssd
// Weighted mean squared difference over one patch, cost in unsigned Q16.8.
//
//   channel   dir   handshake        beat
//   req_if    in    valid / ready    one pixel: source, known, dense, hole, last
//   rsp_if    out   valid / ready    one cost per patch: cost, zero_weight
//   csr_*     in    write enable     dense_weight, unsigned Q4.12
//
// Pixels are taken one per cycle unless the front stalls; the accumulate pipeline is three stages deep.
// Each patch then passes through the back end: pop, fifty one-bit restoring
// division steps, and the hand-off to the response register; a zero weight
// sum skips the division steps.
// Reset is synchronous and clears the sums, the queue and the handshakes;
// dense_weight returns to 1.0. The front stalls only when a last beat meets a
// full queue; the response register lets the divider start the next patch.
// ----------------------------------------------------------------------------
module masked_weighted_patch_ssd #(
   parameter int QueueDepth = mwpssd_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   mwpssd_req_if.sink                      req_if,
   mwpssd_rsp_if.source                    rsp_if,
   input  logic                            csr_we,
   input  logic [mwpssd_pkg::WEIGHT_W-1:0] csr_wdata
);
   import mwpssd_pkg::*;

   logic [WEIGHT_W-1:0]  dense_weight_ff;
   logic                 queue_full;
   logic                 push;
   sums_type             push_data;
   logic                 pop;
   logic                 pop_valid;
   sums_type             pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         dense_weight_ff <= ONE_Q12;
      end else if (csr_we) begin
         dense_weight_ff <= csr_wdata;
      end
   end

   mwpssd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .dense_weight (dense_weight_ff),
      .req          (req_if),
      .queue_full   (queue_full),
      .push         (push),
      .push_data    (push_data)
   );

   mwpssd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   mwpssd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp       (rsp_if)
   );

endmodule

>>> hw/rtl/mwpssd_front.sv
// ----------------------------------------------------------------------------
// mwpssd_front
// Takes pixel beats, forms the weighted squared difference over a short
// pipeline and accumulates both sums; hands finished sums to the queue.
// ----------------------------------------------------------------------------
module mwpssd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mwpssd_pkg::WEIGHT_W-1:0] dense_weight,
   mwpssd_req_if.sink                    req,
   input  logic                          queue_full,
   output logic                          push,
   output mwpssd_pkg::sums_type          push_data
);
   import mwpssd_pkg::*;

   logic                  advance;
   logic [PIXEL_W-1:0]    target;
   logic [PIXEL_W-1:0]    diff;
   logic [WEIGHT_W-1:0]   weight;

   logic                  s0_valid_ff, s0_valid_in;
   logic [PIXEL_W-1:0]    s0_diff_ff;
   logic [WEIGHT_W-1:0]   s0_weight_ff;
   logic                  s0_last_ff;

   logic                  s1_valid_ff, s1_valid_in;
   logic [SQ_W-1:0]       s1_sq_ff;
   logic [WEIGHT_W-1:0]   s1_weight_ff;
   logic                  s1_last_ff;

   logic                  s2_valid_ff, s2_valid_in;
   logic [TERM_W-1:0]     s2_term_ff;
   logic [WEIGHT_W-1:0]   s2_weight_ff;
   logic                  s2_last_ff;

   logic [DIST_W-1:0]     dist_ff, dist_in;
   logic [WSUM_W-1:0]     wsum_ff, wsum_in;
   logic [DIST_W:0]       dist_add;
   logic [WSUM_W:0]       wsum_add;
   logic [DIST_W-1:0]     dist_sat;
   logic [WSUM_W-1:0]     wsum_sat;

   // whole pipeline stalls only when a last beat cannot enter the queue
   assign advance   = !(s2_valid_ff && s2_last_ff && queue_full);
   assign req.ready = advance;

   always_comb begin
      target = req.is_hole ? req.dense_pixel : req.known_pixel;
      weight = req.is_hole ? dense_weight : ONE_Q12;
      diff   = (target >= req.source_pixel) ? (target - req.source_pixel)
                                            : (req.source_pixel - target);
   end

   always_comb begin
      dist_add = {1'b0, dist_ff} + (DIST_W + 1)'(s2_term_ff);
      wsum_add = {1'b0, wsum_ff} + (WSUM_W + 1)'(s2_weight_ff);
      dist_sat = dist_add[DIST_W] ? '1 : dist_add[DIST_W-1:0];
      wsum_sat = wsum_add[WSUM_W] ? '1 : wsum_add[WSUM_W-1:0];
   end

   always_comb begin
      s0_valid_in = s0_valid_ff;
      s1_valid_in = s1_valid_ff;
      s2_valid_in = s2_valid_ff;
      dist_in     = dist_ff;
      wsum_in     = wsum_ff;
      push        = 1'b0;
      if (advance) begin
         s0_valid_in = req.valid;
         s1_valid_in = s0_valid_ff;
         s2_valid_in = s1_valid_ff;
         if (s2_valid_ff) begin
            if (s2_last_ff) begin
               push    = 1'b1;
               dist_in = '0;
               wsum_in = '0;
            end else begin
               dist_in = dist_sat;
               wsum_in = wsum_sat;
            end
         end
      end
   end

   assign push_data.dist_sum = dist_sat;
   assign push_data.wsum     = wsum_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         dist_ff     <= '0;
         wsum_ff     <= '0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         dist_ff     <= dist_in;
         wsum_ff     <= wsum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_diff_ff   <= diff;
         s0_weight_ff <= weight;
         s0_last_ff   <= req.last_pixel;
         s1_sq_ff     <= SQ_W'(s0_diff_ff) * SQ_W'(s0_diff_ff);
         s1_weight_ff <= s0_weight_ff;
         s1_last_ff   <= s0_last_ff;
         s2_term_ff   <= TERM_W'(s1_sq_ff) * TERM_W'(s1_weight_ff);
         s2_weight_ff <= s1_weight_ff;
         s2_last_ff   <= s1_last_ff;
      end
   end

endmodule

>>> hw/rtl/mwpssd_queue.sv
// ----------------------------------------------------------------------------
// mwpssd_queue
// Short first-in first-out queue of finished sum pairs between front and back.
// ----------------------------------------------------------------------------
module mwpssd_queue #(
   parameter int Depth = mwpssd_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mwpssd_pkg::sums_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 pop_valid,
   output mwpssd_pkg::sums_type pop_data
);
   import mwpssd_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   sums_type            mem_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full      = (count_ff == CntW'(Depth));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/mwpssd_back.sv
// ----------------------------------------------------------------------------
// mwpssd_back
// Divides each finished distance sum by its non-zero weight sum one quotient
// bit per cycle, clamps the cost and holds it in the response register.
// ----------------------------------------------------------------------------
module mwpssd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   input  mwpssd_pkg::sums_type pop_data,
   output logic                 pop,
   mwpssd_rsp_if.source         rsp
);
   import mwpssd_pkg::*;

   back_state_type        state_ff, state_in;
   logic [WSUM_W-1:0]     rem_ff, rem_in;
   logic [QUOT_W-1:0]     quot_ff, quot_in;
   logic [WSUM_W-1:0]     divisor_ff;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  zero_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COST_W-1:0]     rsp_cost_ff;
   logic                  rsp_zero_ff;

   logic                  zero_sum;
   logic                  out_free;
   logic                  do_step;
   logic                  load_out;
   logic [WSUM_W:0]       shifted;
   logic [WSUM_W:0]       trial;
   logic                  fits;
   logic [COST_W-1:0]     clamped;

   assign zero_sum = (pop_data.wsum == '0);
   assign out_free = !rsp_valid_ff || rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               state_in = zero_sum ? BK_HOLD : BK_DIVIDE;
            end
         end
         BK_DIVIDE: begin
            if (step_ff == STEP_W'(QUOT_W - 1)) begin
               state_in = BK_HOLD;
            end
         end
         BK_HOLD: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      pop      = 1'b0;
      do_step  = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         BK_IDLE:   pop      = pop_valid;
         BK_DIVIDE: do_step  = 1'b1;
         BK_HOLD:   load_out = out_free;
         default: ;
      endcase
   end

   // restoring division step
   always_comb begin
      shifted = {rem_ff, quot_ff[QUOT_W-1]};
      trial   = shifted - {1'b0, divisor_ff};
      fits    = !trial[WSUM_W];
      clamped = (quot_ff > QUOT_W'(COST_MAX)) ? COST_MAX : quot_ff[COST_W-1:0];
   end

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      if (pop) begin
         rem_in  = '0;
         quot_in = zero_sum ? '1 : {pop_data.dist_sum, FRAC_SHIFT'(0)};
         step_in = '0;
      end else if (do_step) begin
         rem_in  = fits ? trial[WSUM_W-1:0] : shifted[WSUM_W-1:0];
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         step_in = step_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
      if (pop) begin
         divisor_ff <= pop_data.wsum;
         zero_ff    <= zero_sum;
      end
      if (load_out) begin
         rsp_cost_ff <= clamped;
         rsp_zero_ff <= zero_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.cost        = rsp_cost_ff;
   assign rsp.zero_weight = rsp_zero_ff;

endmodule

>>> sim/masked_weighted_patch_ssd_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_weighted_patch_ssd_tb
// Streams patches of pixels into the weighted patch cost block and checks
// every cost beat against a cycle-free model of the weighted mean squared
// difference. Covers the reset weight, zero and full-scale hole weights,
// zero weight sums, saturating accumulators, clamped costs, random patches
// under random gaps on both channels, and a long response stall that backs
// up the pixel channel.
// ----------------------------------------------------------------------------
module masked_weighted_patch_ssd_tb;
   import mwpssd_pkg::*;

   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int SETTLE_CYCLES = 80;
   localparam int PHASE_PIXELS  = 25;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [PIXEL_W-1:0] source_pixel;
      logic [PIXEL_W-1:0] known_pixel;
      logic [PIXEL_W-1:0] dense_pixel;
      logic               is_hole;
      logic               last_pixel;
   } pixel_beat_type;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic              zero_weight;
   } cost_beat_type;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [WEIGHT_W-1:0] csr_wdata;

   mwpssd_req_if req_bus ();
   mwpssd_rsp_if rsp_bus ();

   masked_weighted_patch_ssd uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   logic [DIST_W-1:0]   acc_distance;
   logic [WSUM_W-1:0]   acc_weight;
   logic [WEIGHT_W-1:0] hole_weight;

   cost_beat_type expected_costs [$];

   int  error_count     = 0;
   int  pixels_sent     = 0;
   int  patches_sent    = 0;
   int  costs_checked   = 0;
   int  zero_weight_cnt = 0;
   int  clamped_cnt     = 0;
   int  stall_request   = 0;
   bit  gaps_on         = 1'b1;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [63:0] sat_accumulate(input logic [63:0] acc,
                                                  input logic [63:0] add,
                                                  input int width);
      logic [63:0] limit;
      limit = (64'd1 << width) - 64'd1;
      if (add >= limit || acc > limit - add) return limit;
      return acc + add;
   endfunction

   // one accepted pixel beat into the running sums
   task automatic predict_cost(input pixel_beat_type px);
      logic [PIXEL_W-1:0]  target;
      logic [PIXEL_W-1:0]  diff;
      logic [63:0]         diff64;
      logic [63:0]         w64;
      logic [63:0]         quot;
      cost_beat_type       res;
      target = px.is_hole ? px.dense_pixel : px.known_pixel;
      w64    = px.is_hole ? 64'(hole_weight) : 64'(ONE_Q12);
      diff   = (target >= px.source_pixel) ? target - px.source_pixel
                                           : px.source_pixel - target;
      diff64 = {56'd0, diff};
      acc_distance = DIST_W'(sat_accumulate({22'd0, acc_distance},
                                            diff64 * diff64 * w64, DIST_W));
      acc_weight   = WSUM_W'(sat_accumulate({38'd0, acc_weight}, w64, WSUM_W));
      if (px.last_pixel) begin
         if (acc_weight == '0) begin
            res.cost        = COST_MAX;
            res.zero_weight = 1'b1;
            zero_weight_cnt++;
         end else begin
            quot = ({22'd0, acc_distance} << FRAC_SHIFT) / {38'd0, acc_weight};
            if (quot >= {40'd0, COST_MAX}) begin
               quot = {40'd0, COST_MAX};
               clamped_cnt++;
            end
            res.cost        = quot[COST_W-1:0];
            res.zero_weight = 1'b0;
         end
         expected_costs = {expected_costs, res};
         acc_distance = '0;
         acc_weight   = '0;
         patches_sent++;
      end
   endtask

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
   endtask

   task automatic send_pixel(input pixel_beat_type px);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.source_pixel <= px.source_pixel;
      req_bus.known_pixel  <= px.known_pixel;
      req_bus.dense_pixel  <= px.dense_pixel;
      req_bus.is_hole      <= px.is_hole;
      req_bus.last_pixel   <= px.last_pixel;
      do @(posedge clock); while (!req_bus.ready);
      predict_cost(px);
      pixels_sent++;
   endtask

   task automatic send_fields(input logic [7:0] src, input logic [7:0] known,
                              input logic [7:0] dense, input logic hole,
                              input logic last);
      pixel_beat_type px;
      px = '{src, known, dense, hole, last};
      send_pixel(px);
   endtask

   function automatic logic [PIXEL_W-1:0] rand_pixel();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return '1;
      return PIXEL_W'($urandom_range(0, 255));
   endfunction

   task automatic send_random_patch(input int len, input int hole_pct);
      pixel_beat_type px;
      for (int i = 0; i < len; i++) begin
         px.source_pixel = rand_pixel();
         px.known_pixel  = rand_pixel();
         px.dense_pixel  = rand_pixel();
         if ($urandom_range(0, 9) == 0) begin
            px.known_pixel = px.source_pixel;
            px.dense_pixel = px.source_pixel;
         end
         px.is_hole    = ($urandom_range(0, 99) < hole_pct);
         px.last_pixel = (i == len - 1);
         send_pixel(px);
      end
   endtask

   // pixel channel quiet and every cost beat back
   task automatic wait_for_costs();
      req_bus.valid <= 1'b0;
      while (expected_costs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_weight(input logic [WEIGHT_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      hole_weight = value;
   endtask

   task automatic test_default_weight();
      send_fields(8'd0,   8'd255, 8'd0,   1'b0, 1'b1);
      send_fields(8'd255, 8'd255, 8'd0,   1'b0, 1'b1);
      send_fields(8'd0,   8'd0,   8'd255, 1'b1, 1'b1);
      send_fields(8'd10,  8'd20,  8'd200, 1'b0, 1'b0);
      send_fields(8'd200, 8'd0,   8'd50,  1'b1, 1'b0);
      send_fields(8'd77,  8'd77,  8'd0,   1'b0, 1'b1);
      wait_for_costs();
   endtask

   task automatic test_weight_extremes();
      write_weight(16'd0);
      // an all-hole patch with zero weight, then a patch that mixes in a known pixel
      send_fields(8'd0,   8'd0,   8'd255, 1'b1, 1'b0);
      send_fields(8'd255, 8'd0,   8'd0,   1'b1, 1'b1);
      send_fields(8'd3,   8'd0,   8'd9,   1'b1, 1'b0);
      send_fields(8'd5,   8'd9,   8'd0,   1'b0, 1'b1);
      wait_for_costs();
      write_weight(16'hFFFF);
      send_fields(8'd0,   8'd0,   8'd255, 1'b1, 1'b1);
      send_fields(8'd1,   8'd0,   8'd3,   1'b1, 1'b0);
      send_fields(8'd4,   8'd6,   8'd0,   1'b0, 1'b1);
      wait_for_costs();
      write_weight(16'd1);
      send_fields(8'd0,   8'd0,   8'd255, 1'b1, 1'b0);
      send_fields(8'd100, 8'd101, 8'd0,   1'b0, 1'b1);
      wait_for_costs();
   endtask

   task automatic test_accumulator_saturation();
      write_weight(16'hFFFF);
      for (int i = 0; i < 1040; i++)
         send_fields(8'd0, 8'd0, 8'd255, 1'b1, i == 1039);
      wait_for_costs();
   endtask

   task automatic test_random_patches();
      int len;
      int sent;
      int hole_pct;
      int r;
      logic [WEIGHT_W-1:0] w;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: w = WEIGHT_W'($urandom_range(0, 65535));
            1: w = 16'd0;
            2: w = 16'hFFFF;
            3: w = ONE_Q12;
            default: w = WEIGHT_W'($urandom_range(1, 64));
         endcase
         write_weight(w);
         gaps_on = (phase != 3);
         sent = 0;
         while (sent < PHASE_PIXELS) begin
            r = $urandom_range(0, 99);
            if (r < 80) len = $urandom_range(1, 8);
            else if (r < 97) len = $urandom_range(9, 40);
            else len = $urandom_range(41, 160);
            case ($urandom_range(0, 3))
               0: hole_pct = 0;
               1: hole_pct = 100;
               2: hole_pct = 50;
               default: hole_pct = $urandom_range(0, 100);
            endcase
            send_random_patch(len, hole_pct);
            sent += len;
         end
         wait_for_costs();
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_backpressure();
      write_weight(WEIGHT_W'($urandom_range(0, 65535)));
      gaps_on = 1'b0;
      stall_request = 400;
      for (int i = 0; i < 40; i++)
         send_random_patch($urandom_range(1, 2), 50);
      gaps_on = 1'b1;
      wait_for_costs();
   endtask

   // response ready, random holds plus long requested stalls
   initial begin : cost_ready_drive
      int n;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (stall_request > 0) begin
            n = stall_request;
            stall_request = 0;
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (gaps_on && $urandom_range(0, 99) < 25) begin
            rsp_bus.ready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : cost_checker
      cost_beat_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_costs.size() == 0) begin
               flag_error($sformatf("unexpected beat: cost %0d zero_weight %0b",
                                    rsp_bus.cost, rsp_bus.zero_weight));
            end else begin
               want = expected_costs.pop_front();
               if (rsp_bus.cost !== want.cost)
                  flag_error($sformatf("cost: expected %0d actual %0d",
                                       want.cost, rsp_bus.cost));
               if (rsp_bus.zero_weight !== want.zero_weight)
                  flag_error($sformatf("zero_weight: expected %0b actual %0b",
                                       want.zero_weight, rsp_bus.zero_weight));
               costs_checked++;
            end
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : main_sequence
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_wdata            = '0;
      req_bus.valid        = 1'b0;
      req_bus.source_pixel = '0;
      req_bus.known_pixel  = '0;
      req_bus.dense_pixel  = '0;
      req_bus.is_hole      = 1'b0;
      req_bus.last_pixel   = 1'b0;
      hole_weight          = ONE_Q12;
      acc_distance         = '0;
      acc_weight           = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_weight();
      test_weight_extremes();
      test_accumulator_saturation();
      test_random_patches();
      test_backpressure();

      wait_for_costs();
      if (expected_costs.size() != 0)
         flag_error($sformatf("%0d cost beats never arrived", expected_costs.size()));

      $display("run covered %0d pixels in %0d patches, %0d costs checked",
               pixels_sent, patches_sent, costs_checked);
      $display("hole weights 0, 1, 1.0, full scale and random; %0d zero-weight, %0d clamped",
               zero_weight_cnt, clamped_cnt);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d errors", error_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
